[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// condition must never hold
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");

`endif

[rtl/nmearmc_pkg.sv]
// constants and types for the nmea rmc fix detector
package nmearmc_pkg;

   localparam int TagWidth  = 40;
   localparam int ByteWidth = 8;
   localparam int TagChars  = 5;
   localparam int CsrIndexWidth = 2;

   localparam logic [ByteWidth-1:0] CharDollar = 8'h24;
   localparam logic [ByteWidth-1:0] CharStar   = 8'h2A;
   localparam logic [ByteWidth-1:0] CharA      = 8'h41;
   localparam logic [ByteWidth-1:0] CharD      = 8'h44;

   localparam logic [TagWidth-1:0]  TagReset    = 40'h474E524D43;
   localparam logic [ByteWidth-1:0] TargetReset = 8'd30;
   localparam logic [ByteWidth-1:0] LimitReset  = 8'd120;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SENTENCE_TAG = 2'd0,
      CSR_FIX_TARGET   = 2'd1,
      CSR_FAIL_LIMIT   = 2'd2
   } csr_index_type;

   typedef logic [ByteWidth-1:0] byte_type;

endpackage

[rtl/nmea_rmc_fix_detector_unit.sv]
// nmea rmc fix detector: sentence tag match and fix/failure counting per byte
// an accepted req transaction is registered into the rsp register
// throughput: one byte per cycle while rsp_ready holds; the rsp register frees req_ready when taken
// all per-byte work is one pass of compares and 8-bit adds into the state regs
// reset: synchronous, active high; state and counts clear, registers take defaults
`include "assert_macros.svh"

module nmea_rmc_fix_detector_unit
   import nmearmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_fix_acquired,
   output logic                     rsp_gave_up,
   output logic                     rsp_tag_matched,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [TagWidth-1:0]      csr_data
);

   logic [TagWidth-1:0] sentence_tag_ff;
   byte_type            fix_target_ff;
   byte_type            fail_limit_ff;

   byte_type            line_pos_ff, line_pos_in;
   logic                in_header_ff, in_header_in;
   logic                recog_ff, recog_in;
   byte_type            header_ff [TagChars];
   byte_type            header_in [TagChars];
   byte_type            prev_byte_ff, prev_byte_in;
   byte_type            fix_count_ff, fix_count_in;
   byte_type            fail_count_ff, fail_count_in;

   logic                rsp_valid_ff;
   logic                rsp_fix_acquired_ff, rsp_fix_acquired_in;
   logic                rsp_gave_up_ff, rsp_gave_up_in;
   logic                rsp_tag_matched_ff;

   logic                accept;
   logic                header_match;
   byte_type            fix_inc;
   byte_type            rx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rx        = req_rx_byte;
   assign fix_inc   = fix_count_ff + 8'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sentence_tag_ff <= TagReset;
         fix_target_ff   <= TargetReset;
         fail_limit_ff   <= LimitReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SENTENCE_TAG: sentence_tag_ff <= csr_data;
            CSR_FIX_TARGET:   fix_target_ff   <= csr_data[ByteWidth-1:0];
            CSR_FAIL_LIMIT:   fail_limit_ff   <= csr_data[ByteWidth-1:0];
            default: ;
         endcase
      end
   end

   // header storage and compare, including this byte
   always_comb begin
      header_match = 1'b1;
      for (int k = 0; k < TagChars; k++) begin
         header_in[k] = (line_pos_ff == ByteWidth'(k + 1)) ? rx : header_ff[k];
         if (header_in[k] != sentence_tag_ff[ByteWidth*(TagChars-1-k) +: ByteWidth]) begin
            header_match = 1'b0;
         end
      end
   end

   always_comb begin
      line_pos_in         = line_pos_ff;
      in_header_in        = in_header_ff;
      recog_in            = recog_ff;
      prev_byte_in        = prev_byte_ff;
      fix_count_in        = fix_count_ff;
      fail_count_in       = fail_count_ff;
      rsp_fix_acquired_in = 1'b0;
      rsp_gave_up_in      = 1'b0;
      if (rx == CharDollar) begin
         recog_in     = 1'b0;
         in_header_in = 1'b1;
         prev_byte_in = rx;
         line_pos_in  = 8'd1;
      end else if (rx == CharStar) begin
         if (recog_ff) begin
            if (prev_byte_ff == CharA || prev_byte_ff == CharD) begin
               fix_count_in = fix_inc;
               if (fix_inc == fix_target_ff) begin
                  rsp_fix_acquired_in = 1'b1;
                  fix_count_in        = '0;
                  fail_count_in       = '0;
               end
            end else if (fail_count_ff == fail_limit_ff) begin
               rsp_gave_up_in = 1'b1;
               fail_count_in  = '0;
               fix_count_in   = '0;
            end else begin
               fail_count_in = fail_count_ff + 8'd1;
               fix_count_in  = '0;
            end
         end
         in_header_in = 1'b0;
      end else begin
         if (in_header_ff && line_pos_ff >= 8'd5 && header_match) begin
            recog_in = 1'b1;
         end
         prev_byte_in = rx;
         line_pos_in  = line_pos_ff + 8'd1;
      end
   end

   // sentence state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff   <= '0;
         in_header_ff  <= 1'b0;
         recog_ff      <= 1'b0;
         prev_byte_ff  <= '0;
         fix_count_ff  <= '0;
         fail_count_ff <= '0;
         for (int k = 0; k < TagChars; k++) begin
            header_ff[k] <= '0;
         end
      end else if (accept) begin
         line_pos_ff   <= line_pos_in;
         in_header_ff  <= in_header_in;
         recog_ff      <= recog_in;
         prev_byte_ff  <= prev_byte_in;
         fix_count_ff  <= fix_count_in;
         fail_count_ff <= fail_count_in;
         for (int k = 0; k < TagChars; k++) begin
            header_ff[k] <= header_in[k];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_fix_acquired_ff <= rsp_fix_acquired_in;
         rsp_gave_up_ff      <= rsp_gave_up_in;
         rsp_tag_matched_ff  <= recog_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fix_acquired = rsp_fix_acquired_ff;
   assign rsp_gave_up      = rsp_gave_up_ff;
   assign rsp_tag_matched  = rsp_tag_matched_ff;

   `ASSERT_NEVER(a_acq_and_gave_up, clock, reset, rsp_valid_ff && rsp_fix_acquired_ff && rsp_gave_up_ff)
   `ASSERT_NEXT_CYCLE(a_acq_clears, clock, reset, accept && rsp_fix_acquired_in, fix_count_ff == 8'd0 && fail_count_ff == 8'd0)
   `ASSERT_NEXT_CYCLE(a_dollar_opens, clock, reset, accept && rx == CharDollar, line_pos_ff == 8'd1 && in_header_ff && !recog_ff)
   `ASSERT_SAME_CYCLE(a_match_follows_state, clock, reset, rsp_valid_ff && rsp_tag_matched_ff && !accept, recog_ff)

endmodule
